// ----- design/rm_majority_logic_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// rm_majority_logic_decoder_defines
// assertion macros shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef RM_MAJORITY_LOGIC_DECODER_DEFINES_SVH
`define RM_MAJORITY_LOGIC_DECODER_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define RMD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rmd assertion failed");

// consequence that must hold in the cycle after the antecedent
`define RMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmd assertion failed");

`else

`define RMD_ASSERT(label, prop)
`define RMD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// rmd_pkg
// shared widths, register map and constant helpers of the reed-muller decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rmd_pkg;

    localparam int ORDER_W    = 3;
    localparam int LEN_W      = 6;
    localparam int MSG_W      = 32;
    localparam int MSG_IDX_W  = 5;
    localparam int CW_W       = 32;
    localparam int OUT_DATA_W = 40;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_CODE_ORDER_ADDR = 2'd0;
    localparam logic [ORDER_W-1:0]    CODE_ORDER_RESET    = 3'd1;

    // n choose k as the count of n-bit masks with k bits set
    function automatic int binom(input int n, input int k);
        int cnt;
        cnt = 0;
        for (int v = 0; v < (1 << n); v++)
        begin
            if ($countones(v) == k)
            begin
                cnt = cnt + 1;
            end
        end
        return cnt;
    endfunction

    // index of the first monomial of a given degree
    function automatic int base_index(input int n, input int deg);
        int sum;
        sum = 0;
        for (int k = 0; k < deg; k++)
        begin
            sum = sum + binom(n, k);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

// ----- design/rm_majority_logic_decoder.sv -----
// ----------------------------------------------------------------------------
// rm_majority_logic_decoder
// reed-muller majority-logic decoder, one stage per monomial degree
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one received codeword per transfer (tdata[31:0], only the
//   low 2^NUM_VARS bits are used). m_axis returns one result per codeword:
//   decoded message, message length and a tie flag.
//   the apb port holds code_order at address 0; orders above NUM_VARS decode
//   as NUM_VARS. write it only while no codeword is in flight.
//   the result passes through one register stage per degree, NUM_VARS down
//   to 0, each holding the vote trees of that degree.
//   a new codeword can enter every cycle unless the output stalls.
//   when m_axis_tready is low with a result waiting, the whole pipeline
//   freezes and s_axis_tready drops; nothing is lost or repeated. bubbles
//   stay in place during such a stall.
//   reset empties the pipeline and sets code_order to 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rm_majority_logic_decoder_defines.svh"

module rm_majority_logic_decoder
    import rmd_pkg::*;
#(
    parameter int NUM_VARS = 5
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // apb configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [CW_W-1:0]       s_axis_tdata,   // [31:0] codeword
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata    // [31:0] message,
                                                       // [37:32] message_length,
                                                       // [38] tie_error, [39] zero
);

    localparam int WORD_LEN = 1 << NUM_VARS;
    localparam int NSTAGE   = NUM_VARS + 1;

    logic [ORDER_W-1:0]  code_order;
    logic [ORDER_W-1:0]  order_clip;
    logic                ce;

    logic                valid_c [NSTAGE+1];
    logic [WORD_LEN-1:0] word_c  [NSTAGE+1];
    logic [MSG_W-1:0]    msg_c   [NSTAGE+1];
    logic                tie_c   [NSTAGE+1];
    logic [ORDER_W-1:0]  order_c [NSTAGE+1];

    logic [MSG_W-1:0]    message;
    logic [LEN_W-1:0]    message_length;
    logic                tie_error;

    function automatic logic [LEN_W-1:0] msg_len(input logic [ORDER_W-1:0] r);
        int sum;
        sum = 0;
        for (int k = 0; k <= NUM_VARS; k++)
        begin
            if (k <= int'(r))
            begin
                sum = sum + binom(NUM_VARS, k);
            end
        end
        return LEN_W'(sum);
    endfunction

    rmd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .code_order (code_order)
    );

    assign order_clip = (code_order > ORDER_W'(NUM_VARS)) ? ORDER_W'(NUM_VARS) : code_order;

    // pipeline moves whenever the output slot is empty or being taken
    assign ce            = m_axis_tready || !valid_c[NSTAGE];
    assign s_axis_tready = ce;

    assign valid_c[0] = s_axis_tvalid;
    assign word_c[0]  = s_axis_tdata[WORD_LEN-1:0];
    assign msg_c[0]   = '0;
    assign tie_c[0]   = 1'b0;
    assign order_c[0] = order_clip;

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_stage
        rmd_stage #(
            .NUM_VARS (NUM_VARS),
            .DEGREE   (NUM_VARS - g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .valid_in  (valid_c[g]),
            .word_in   (word_c[g]),
            .msg_in    (msg_c[g]),
            .tie_in    (tie_c[g]),
            .order_in  (order_c[g]),
            .valid_out (valid_c[g+1]),
            .word_out  (word_c[g+1]),
            .msg_out   (msg_c[g+1]),
            .tie_out   (tie_c[g+1]),
            .order_out (order_c[g+1])
        );
    end

    assign message        = msg_c[NSTAGE];
    assign message_length = msg_len(order_c[NSTAGE]);
    assign tie_error      = tie_c[NSTAGE];

    assign m_axis_tvalid = valid_c[NSTAGE];
    assign m_axis_tdata  = {1'b0, tie_error, message_length, message};

    `RMD_ASSERT(a_msg_tail_zero,
        m_axis_tvalid |-> ((message >> message_length) == '0))
    `RMD_ASSERT(a_order_clipped,
        m_axis_tvalid |-> (order_c[NSTAGE] <= ORDER_W'(NUM_VARS)))

endmodule

`default_nettype wire

// ----- design/rmd_cfg.sv -----
// ----------------------------------------------------------------------------
// rmd_cfg
// apb register block holding the code order
// ----------------------------------------------------------------------------
`default_nettype none

`include "rm_majority_logic_decoder_defines.svh"

module rmd_cfg
    import rmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [ORDER_W-1:0]    code_order
);

    logic               wr_en;
    logic [ORDER_W-1:0] code_order_reg;
    logic [ORDER_W-1:0] code_order_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        code_order_next = code_order_reg;
        if (wr_en && (paddr == REG_CODE_ORDER_ADDR))
        begin
            code_order_next = pwdata[ORDER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_order_reg <= CODE_ORDER_RESET;
        end
        else
        begin
            code_order_reg <= code_order_next;
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_CODE_ORDER_ADDR:
            begin
                prdata = {{(APB_DATA_W-ORDER_W){1'b0}}, code_order_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign code_order = code_order_reg;

    `RMD_ASSERT_NEXT(a_order_written, wr_en && (paddr == REG_CODE_ORDER_ADDR),
        code_order_reg == $past(pwdata[ORDER_W-1:0]))

endmodule

`default_nettype wire

// ----- design/rmd_stage.sv -----
// ----------------------------------------------------------------------------
// rmd_stage
// one degree of majority-logic decoding: votes, message bits and word update
// ----------------------------------------------------------------------------
`default_nettype none

`include "rm_majority_logic_decoder_defines.svh"

module rmd_stage
    import rmd_pkg::*;
#(
    parameter int NUM_VARS = 5,
    parameter int DEGREE   = 0
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       ce,
    input  wire logic                       valid_in,
    input  wire logic [(1<<NUM_VARS)-1:0]   word_in,
    input  wire logic [MSG_W-1:0]           msg_in,
    input  wire logic                       tie_in,
    input  wire logic [ORDER_W-1:0]         order_in,
    output logic                            valid_out,
    output logic      [(1<<NUM_VARS)-1:0]   word_out,
    output logic      [MSG_W-1:0]           msg_out,
    output logic                            tie_out,
    output logic      [ORDER_W-1:0]         order_out
);

    localparam int WORD_LEN = 1 << NUM_VARS;
    localparam int VOTES    = 1 << (NUM_VARS - DEGREE);
    localparam int BASE     = base_index(NUM_VARS, DEGREE);
    localparam logic [NUM_VARS+1:0] VOTES_X = (NUM_VARS+2)'(VOTES);

    logic                valid_reg;
    logic [WORD_LEN-1:0] word_reg;
    logic [MSG_W-1:0]    msg_reg;
    logic                tie_reg;
    logic [ORDER_W-1:0]  order_reg;

    logic [WORD_LEN-1:0] word_next;
    logic [MSG_W-1:0]    msg_next;
    logic                tie_next;

    logic                active;
    logic [WORD_LEN-1:0] fix;
    logic [MSG_W-1:0]    bits;
    logic                tie_any;

    // positions p whose bits outside the monomial mask equal a
    function automatic logic [WORD_LEN-1:0] coset_mask(input int vm, input int a);
        logic [WORD_LEN-1:0] m;
        m = '0;
        for (int p = 0; p < WORD_LEN; p++)
        begin
            if (((p & ~vm) & (WORD_LEN - 1)) == a)
            begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    // evaluation row of a monomial
    function automatic logic [WORD_LEN-1:0] eval_row(input int vm);
        logic [WORD_LEN-1:0] m;
        m = '0;
        for (int p = 0; p < WORD_LEN; p++)
        begin
            if ((p & vm) == 0)
            begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    assign active = (order_in >= ORDER_W'(DEGREE));

    always_comb
    begin : vote_logic
        logic [VOTES-1:0]    vote_vec;
        logic [NUM_VARS:0]   ones;
        logic [NUM_VARS+1:0] ones2;
        int                  rank;
        int                  k;
        fix      = '0;
        bits     = '0;
        tie_any  = 1'b0;
        vote_vec = '0;
        ones     = '0;
        ones2    = '0;
        rank     = 0;
        k        = 0;
        // descending masks walk the monomials in ascending variable order
        for (int vi = WORD_LEN - 1; vi >= 0; vi--)
        begin
            if ($countones(vi) == DEGREE)
            begin
                k = 0;
                for (int a = 0; a < WORD_LEN; a++)
                begin
                    if ((a & vi) == 0)
                    begin
                        vote_vec[k] = ^(word_in & coset_mask(vi, a));
                        k = k + 1;
                    end
                end
                ones  = (NUM_VARS+1)'($countones(vote_vec));
                ones2 = {ones, 1'b0};
                if (ones2 == VOTES_X)
                begin
                    tie_any = 1'b1;
                end
                else if (ones2 > VOTES_X)
                begin
                    bits[MSG_IDX_W'(BASE + rank)] = 1'b1;
                    fix = fix ^ eval_row(vi);
                end
                rank = rank + 1;
            end
        end
    end

    assign word_next = active ? (word_in ^ fix) : word_in;
    assign msg_next  = active ? (msg_in | bits) : msg_in;
    assign tie_next  = active ? (tie_in | tie_any) : tie_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            word_reg  <= word_next;
            msg_reg   <= msg_next;
            tie_reg   <= tie_next;
            order_reg <= order_in;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;
    assign msg_out   = msg_reg;
    assign tie_out   = tie_reg;
    assign order_out = order_reg;

    // a degree above the code order leaves the item untouched
    `RMD_ASSERT_NEXT(a_skip_keeps_item, ce && valid_in && !active,
        valid_reg && (word_reg == $past(word_in)) && (msg_reg == $past(msg_in)) &&
        (tie_reg == $past(tie_in)))

endmodule

`default_nettype wire

// ----- bench/rm_majority_logic_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// rm_majority_logic_decoder_tb
// self-checking bench for the reed-muller majority-logic decoder
// ----------------------------------------------------------------------------
// Codewords go into the input stream and each result is checked against a
// predictor that runs the same majority votes degree by degree. The code order
// is changed over the apb port between phases, once the decoder is empty, and
// covers every order from 0 to 7. Most random words are clean codewords of the
// current order with a few flipped bits. The rest are random, sparse or dense
// words. Both stream sides idle at random. The output side also holds off
// for a long stretch twice, so that the pipeline fills and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module rm_majority_logic_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rmd_pkg::*;

    localparam int NV               = 5;
    localparam int WORD_BITS        = 1 << NV;
    localparam int NUM_PHASES       = 10;
    localparam int RANDOM_PER_PHASE = 152;
    localparam int LONG_HOLD        = 300;
    localparam int DRAIN_WAIT       = NV + 6;
    localparam int STALL_LIMIT      = 5000;

    localparam logic [ORDER_W-1:0] PHASE_ORDERS [8] =
        '{3'd0, 3'd5, 3'd1, 3'd7, 3'd2, 3'd4, 3'd6, 3'd3};

    // matches the m_axis_tdata layout, lowest field last
    typedef struct packed {
        logic             pad;
        logic             tie;
        logic [LEN_W-1:0] len;
        logic [MSG_W-1:0] msg;
    } decode_result_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CW_W-1:0]       s_axis_tdata  = '0;   // [31:0] codeword
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] message, [37:32] message_length,
                                                 // [38] tie_error, [39] zero

    logic [CW_W-1:0]     codeword_queue [$];
    decode_result_t      expected_decodes [$];
    logic [ORDER_W-1:0]  model_order = CODE_ORDER_RESET;

    bit sender_idle_on   = 1'b0;
    bit receiver_idle_on = 1'b0;
    bit long_hold_armed  = 1'b0;
    int send_gap         = 0;
    int hold_cycles      = 0;
    int mismatch_count   = 0;
    int results_checked  = 0;
    int tie_results      = 0;
    int long_holds_done  = 0;
    int stall_cycles     = 0;

    rm_majority_logic_decoder #(
        .NUM_VARS (NV)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // positions where every variable of the monomial is 0
    function automatic logic [CW_W-1:0] monomial_row(input int vm);
        logic [CW_W-1:0] row;
        row = '0;
        for (int p = 0; p < WORD_BITS; p++)
        begin
            if ((p & vm) == 0)
                row[p] = 1'b1;
        end
        return row;
    endfunction

    function automatic int clamp_order(input logic [ORDER_W-1:0] order);
        return (order > NV) ? NV : int'(order);
    endfunction

    function automatic decode_result_t decode_codeword(input logic [CW_W-1:0] cw,
                                                       input logic [ORDER_W-1:0] order);
        decode_result_t  res;
        logic [CW_W-1:0] word;
        logic [CW_W-1:0] fix;
        logic [CW_W-1:0] coset;
        int              first_idx [NV+2];
        int              r;
        int              cnt;
        int              rank;
        int              votes;
        int              ones;
        word = '0;
        for (int p = 0; p < WORD_BITS; p++)
            word[p] = cw[p];
        r   = clamp_order(order);
        res = '0;
        first_idx[0] = 0;
        for (int d = 0; d <= NV; d++)
        begin
            cnt = 0;
            for (int v = 0; v < WORD_BITS; v++)
            begin
                if ($countones(v) == d)
                    cnt++;
            end
            first_idx[d+1] = first_idx[d] + cnt;
        end
        for (int d = r; d >= 0; d--)
        begin
            rank = 0;
            fix  = '0;
            // descending masks give ascending variable positions
            for (int vm = WORD_BITS - 1; vm >= 0; vm--)
            begin
                if ($countones(vm) != d)
                    continue;
                votes = 0;
                ones  = 0;
                for (int a = 0; a < WORD_BITS; a++)
                begin
                    if ((a & vm) != 0)
                        continue;
                    coset = '0;
                    for (int p = 0; p < WORD_BITS; p++)
                    begin
                        if ((p & ~vm & (WORD_BITS - 1)) == a)
                            coset[p] = 1'b1;
                    end
                    votes++;
                    ones += int'(^(word & coset));
                end
                if (ones * 2 == votes)
                    res.tie = 1'b1;
                else if (ones * 2 > votes)
                begin
                    res.msg[(first_idx[d] + rank) % MSG_W] = 1'b1;
                    fix ^= monomial_row(vm);
                end
                rank++;
            end
            word ^= fix;
        end
        res.len = LEN_W'(first_idx[r+1]);
        return res;
    endfunction

    function automatic logic [CW_W-1:0] encode_message(input logic [MSG_W-1:0] msg,
                                                       input logic [ORDER_W-1:0] order);
        logic [CW_W-1:0] cw;
        int              j;
        cw = '0;
        j  = 0;
        for (int d = 0; d <= clamp_order(order); d++)
        begin
            for (int vm = WORD_BITS - 1; vm >= 0; vm--)
            begin
                if ($countones(vm) == d)
                begin
                    if (msg[j])
                        cw ^= monomial_row(vm);
                    j++;
                end
            end
        end
        return cw;
    endfunction

    function automatic logic [CW_W-1:0] random_codeword(input logic [ORDER_W-1:0] order);
        logic [CW_W-1:0] cw;
        int              kind;
        int              bit_pos;
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            // valid codeword with a few errors
            cw = encode_message($urandom(), order);
            repeat ($urandom_range(0, 4))
            begin
                bit_pos = $urandom_range(0, WORD_BITS - 1);
                cw[bit_pos] = ~cw[bit_pos];
            end
        end
        else if (kind < 80)
            cw = $urandom();
        else
        begin
            cw = (kind < 90) ? '0 : '1;
            repeat ($urandom_range(1, 6))
            begin
                bit_pos = $urandom_range(0, WORD_BITS - 1);
                cw[bit_pos] = ~cw[bit_pos];
            end
        end
        return cw;
    endfunction

    // mostly short, now and then long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic apb_access(input logic is_write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= REG_CODE_ORDER_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_code_order(input logic [ORDER_W-1:0] want);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== APB_DATA_W'(want))
            note_mismatch("code_order readback", 64'(want), 64'(rdata));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (codeword_queue.size() != 0 || s_axis_tvalid || expected_decodes.size() != 0);
    endtask

    // register model follows the bus
    always @(posedge clk)
    begin
        if (!rst_n)
            model_order <= CODE_ORDER_RESET;
        else if (psel && penable && pwrite && pready && paddr == REG_CODE_ORDER_ADDR)
            model_order <= pwdata[ORDER_W-1:0];
    end

    // input side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_decodes.push_back(decode_codeword(s_axis_tdata, model_order));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (codeword_queue.size() != 0)
                begin
                    s_axis_tdata  <= codeword_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (sender_idle_on && $urandom_range(0, 9) < 3)
                        send_gap = idle_length();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge clk)
    begin : result_check
        decode_result_t got;
        decode_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                results_checked++;
                if (got.tie)
                    tie_results++;
                if (expected_decodes.size() == 0)
                    note_mismatch("unexpected result", 64'd0, 64'(got));
                else
                begin
                    want = expected_decodes.pop_front();
                    if (got.msg !== want.msg)
                        note_mismatch("message", 64'(want.msg), 64'(got.msg));
                    if (got.len !== want.len)
                        note_mismatch("message_length", 64'(want.len), 64'(got.len));
                    if (got.tie !== want.tie)
                        note_mismatch("tie_error", 64'(want.tie), 64'(got.tie));
                    if (got.pad !== 1'b0)
                        note_mismatch("tdata pad bit", 64'd0, 64'(got.pad));
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_armed && m_axis_tvalid)
            begin
                // long back-pressure so the pipeline fills up
                long_hold_armed = 1'b0;
                long_holds_done++;
                hold_cycles = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (receiver_idle_on && $urandom_range(0, 3) == 0)
            begin
                hold_cycles = idle_length() - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, expected_decodes.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ORDER_W-1:0]    order;
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] unused_rdata;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        check_code_order(CODE_ORDER_RESET);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            order = (phase < 8) ? PHASE_ORDERS[phase] : ORDER_W'($urandom_range(0, 7));
            // upper bits of the write are junk and must be dropped
            wdata = $urandom();
            wdata[ORDER_W-1:0] = order;
            apb_access(1'b1, wdata, unused_rdata);
            check_code_order(order);

            sender_idle_on   = (phase != 1) && ($urandom_range(0, 3) != 0);
            receiver_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            if (phase == 2 || phase == 6)
                long_hold_armed = 1'b1;

            // all-zero, all-one and a balanced word that ties at order 0
            codeword_queue.push_back('0);
            codeword_queue.push_back('1);
            codeword_queue.push_back(32'h0000_ffff);
            if (phase == 0)
            begin
                codeword_queue.push_back(32'h0000_0001);
                codeword_queue.push_back(32'haaaa_aaaa);
            end
            repeat (RANDOM_PER_PHASE)
                codeword_queue.push_back(random_codeword(order));

            wait_drained();
            repeat (DRAIN_WAIT) @(posedge clk);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("checked %0d decodes over %0d code order settings, %0d of them with a tie",
                 results_checked, NUM_PHASES, tie_results);
        $display("output held off %0d times for %0d cycles under load, %0d mismatches",
                 long_holds_done, LONG_HOLD, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
